// ===== src/mna_pkg.sv =====
package mna_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int COUNT_BITS_DEF  = 24;
   localparam int FRAC_BITS_DEF   = 16;

   // result fields
   localparam int OUT_W    = 48;
   localparam int STATUS_W = 2;

   // the energy sums never grow past this width; each saturates at its own width
   localparam int ACC_MAX_W = 64;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SILENT   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_D,
      ST_ACC_D,
      ST_ACC_O,
      ST_MSE_GO,
      ST_MSE_RUN,
      ST_NMSE_GO,
      ST_NMSE_RUN,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic load;        // capture magnitudes of a new sample pair
      logic square_orig; // multiplier squares the original instead of the difference
      logic acc_en;      // add the product register into a sum
      logic acc_orig;    // which sum: original energy instead of difference energy
      logic clear;       // zero both sums
   } acc_ctl_type;

   // width of the difference energy sum
   function automatic int de_width(int sb, int cb);
      int w;
      w = 2 * sb + cb;
      return (w > ACC_MAX_W) ? ACC_MAX_W : w;
   endfunction

   // width of the original energy sum
   function automatic int oe_width(int sb, int cb);
      int w;
      w = 2 * sb - 1 + cb;
      return (w > ACC_MAX_W) ? ACC_MAX_W : w;
   endfunction

endpackage

// ===== src/mna_accum.sv =====
module mna_accum
   import mna_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   localparam int DE_W = de_width(SAMPLE_BITS, COUNT_BITS),
   localparam int OE_W = oe_width(SAMPLE_BITS, COUNT_BITS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  acc_ctl_type            ctl,
   input  logic [SAMPLE_BITS-1:0] orig_sample,
   input  logic [SAMPLE_BITS-1:0] stego_sample,
   output logic [DE_W-1:0]        diff_energy,
   output logic [OE_W-1:0]        orig_energy
);

   localparam int SB     = SAMPLE_BITS;
   localparam int PROD_W = 2 * SAMPLE_BITS;

   logic [SB-1:0]     abs_d_ff, abs_d_in;
   logic [SB-1:0]     abs_o_ff, abs_o_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DE_W-1:0]   diff_ff, diff_in;
   logic [OE_W-1:0]   orig_ff, orig_in;

   logic [SB:0]       dlt;
   logic [SB:0]       dlt_mag;
   logic [SB-1:0]     mul_op;
   logic [DE_W-1:0]   add_a;
   logic [DE_W:0]     add_sum;

   always_comb begin
      dlt      = {orig_sample[SB-1], orig_sample} - {stego_sample[SB-1], stego_sample};
      dlt_mag  = dlt[SB] ? (~dlt + 1'b1) : dlt;
      abs_d_in = ctl.load ? dlt_mag[SB-1:0] : abs_d_ff;
      abs_o_in = ctl.load ? (orig_sample[SB-1] ? (~orig_sample + 1'b1) : orig_sample)
                          : abs_o_ff;

      // shared multiplier, registered
      mul_op  = ctl.square_orig ? abs_o_ff : abs_d_ff;
      prod_in = mul_op * mul_op;

      // shared saturating adder
      add_a   = ctl.acc_orig ? DE_W'(orig_ff) : diff_ff;
      add_sum = {1'b0, add_a} + (DE_W + 1)'(prod_ff);

      diff_in = diff_ff;
      orig_in = orig_ff;
      if (ctl.clear) begin
         diff_in = '0;
         orig_in = '0;
      end else if (ctl.acc_en && !ctl.acc_orig) begin
         diff_in = add_sum[DE_W] ? {DE_W{1'b1}} : add_sum[DE_W-1:0];
      end else if (ctl.acc_en) begin
         orig_in = (|add_sum[DE_W:OE_W]) ? {OE_W{1'b1}} : add_sum[OE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      abs_d_ff <= abs_d_in;
      abs_o_ff <= abs_o_in;
      prod_ff  <= prod_in;
      if (reset) begin
         diff_ff <= '0;
         orig_ff <= '0;
      end else begin
         diff_ff <= diff_in;
         orig_ff <= orig_in;
      end
   end

   assign diff_energy = diff_ff;
   assign orig_energy = orig_ff;

endmodule

// ===== src/mna_divider.sv =====
module mna_divider
   import mna_pkg::*;
#(
   parameter int NUMER_W   = 56,
   parameter int DENOM_W   = 55,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUMER_W-1:0] dividend,
   input  logic [DENOM_W-1:0] divisor,
   output logic               busy,
   output logic               done,
   output logic [OUT_W-1:0]   quotient
);

   // dividend scaled by 2^FRAC_BITS, one bit consumed per step
   localparam int NUM_W = NUMER_W + FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DENOM_W-1:0] rem_ff, rem_in;
   logic [DENOM_W-1:0] den_ff, den_in;
   logic [OUT_W-1:0]   quo_ff, quo_in;
   logic               sat_ff, sat_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [DENOM_W:0]   trial;
   logic [DENOM_W:0]   trial_sub;
   logic               fits;

   always_comb begin
      trial     = {rem_ff, num_ff[NUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});

      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         num_in  = NUM_W'(dividend) << FRAC_BITS;
         rem_in  = '0;
         den_in  = divisor;
         quo_in  = '0;
         sat_in  = 1'b0;
         cnt_in  = CNT_W'(NUM_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = fits ? trial_sub[DENOM_W-1:0] : trial[DENOM_W-1:0];
         // a bit shifted out of the top means the quotient is past range
         sat_in = sat_ff | quo_ff[OUT_W-1];
         quo_in = {quo_ff[OUT_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(0)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = sat_ff ? {OUT_W{1'b1}} : quo_ff;

endmodule

// ===== src/mse_nmse_accumulator_core.sv =====
// Mean squared error and normalized MSE accumulator. Each request transaction carries one
// pair of signed samples (original and modified, low SAMPLE_BITS used) and a last flag.
// The core sums the squared differences, the squared originals and the pair count; on
// the pair marked last it returns one response transaction with mse = floor(diff energy
// * 2^FRAC_BITS / count) and nmse = floor(diff energy * 2^FRAC_BITS / orig energy), both
// saturated at 2^48-1, then clears its sums. A silent original gives nmse 0 and, if the
// difference energy is nonzero, status 1; pairs that arrive after 2^COUNT_BITS have been
// counted are dropped and give status 2, which wins over status 1. One multiplier and
// one adder are shared under the sequencer, so an accumulated pair occupies the core
// through its steps: accept, square the difference, add it while squaring the original,
// add the original; a dropped pair only through its acceptance. The last pair then adds
// two passes of one restoring divider, one quotient bit per cycle over DE_W + FRAC_BITS
// bits (DE_W = min(2*SAMPLE_BITS + COUNT_BITS, 64)). req_ready is low while the core
// works. A finished response waits in an output register, and the core accepts further
// pairs meanwhile; a second result only waits if the first is still not taken.
module mse_nmse_accumulator_core
   import mna_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_orig_sample,
   input  logic [SAMPLE_BITS-1:0] req_stego_sample,
   input  logic                   req_last,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OUT_W-1:0]       rsp_mse,
   output logic [OUT_W-1:0]       rsp_nmse,
   output logic [STATUS_W-1:0]    rsp_status
);

   localparam int DE_W = de_width(SAMPLE_BITS, COUNT_BITS);
   localparam int OE_W = oe_width(SAMPLE_BITS, COUNT_BITS);
   // orig energy is always at least as wide as the count
   localparam int DV_W = OE_W;

   seq_state_type state_ff, state_in;

   logic [COUNT_BITS:0]  count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic                 last_ff, last_in;
   logic [OUT_W-1:0]     mse_ff, mse_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]     rsp_mse_ff, rsp_mse_in;
   logic [OUT_W-1:0]     rsp_nmse_ff, rsp_nmse_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   acc_ctl_type          acc_ctl;
   logic [DE_W-1:0]      diff_energy;
   logic [OE_W-1:0]      orig_energy;

   logic                 div_start;
   logic                 div_sel_orig;
   logic [DV_W-1:0]      div_divisor;
   logic                 div_busy;
   logic                 div_done;
   logic [OUT_W-1:0]     div_quotient;

   logic                 count_full;
   logic                 out_load;

   assign count_full = count_ff[COUNT_BITS];

   mna_accum #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .ctl          (acc_ctl),
      .orig_sample  (req_orig_sample),
      .stego_sample (req_stego_sample),
      .diff_energy  (diff_energy),
      .orig_energy  (orig_energy)
   );

   // one divider serves both quotients, count first, then original energy
   assign div_divisor = div_sel_orig ? orig_energy : DV_W'(count_ff);

   mna_divider #(
      .NUMER_W   (DE_W),
      .DENOM_W   (DV_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_energy),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // sequencer: next state and control
   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      acc_ctl       = '0;
      div_start     = 1'b0;
      div_sel_orig  = 1'b0;
      out_load      = 1'b0;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      last_in       = last_ff;
      mse_in        = mse_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               acc_ctl.load = 1'b1;
               last_in      = req_last;
               if (count_full) begin
                  // drop the pair, only flag it
                  ovf_in   = 1'b1;
                  state_in = req_last ? ST_MSE_GO : ST_IDLE;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = ST_MUL_D;
               end
            end
         end
         ST_MUL_D: begin
            acc_ctl.square_orig = 1'b0;
            state_in            = ST_ACC_D;
         end
         ST_ACC_D: begin
            acc_ctl.square_orig = 1'b1;
            acc_ctl.acc_en      = 1'b1;
            state_in            = ST_ACC_O;
         end
         ST_ACC_O: begin
            acc_ctl.acc_en   = 1'b1;
            acc_ctl.acc_orig = 1'b1;
            state_in         = last_ff ? ST_MSE_GO : ST_IDLE;
         end
         ST_MSE_GO: begin
            div_start = 1'b1;
            state_in  = ST_MSE_RUN;
         end
         ST_MSE_RUN: begin
            if (div_done) begin
               mse_in   = (count_ff == '0) ? '0 : div_quotient;
               state_in = ST_NMSE_GO;
            end
         end
         ST_NMSE_GO: begin
            div_start    = 1'b1;
            div_sel_orig = 1'b1;
            state_in     = ST_NMSE_RUN;
         end
         ST_NMSE_RUN: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free, then clear for the next run
            if (!rsp_valid_ff || rsp_ready) begin
               out_load      = 1'b1;
               acc_ctl.clear = 1'b1;
               count_in      = '0;
               ovf_in        = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_mse_in    = rsp_mse_ff;
      rsp_nmse_in   = rsp_nmse_ff;
      rsp_status_in = rsp_status_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_mse_in   = mse_ff;
         rsp_nmse_in  = (orig_energy == '0) ? '0 : div_quotient;
         if (ovf_ff) begin
            rsp_status_in = STATUS_OVERFLOW;
         end else if (orig_energy == '0 && diff_energy != '0) begin
            rsp_status_in = STATUS_SILENT;
         end else begin
            rsp_status_in = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      mse_ff        <= mse_in;
      last_ff       <= last_in;
      rsp_mse_ff    <= rsp_mse_in;
      rsp_nmse_ff   <= rsp_nmse_in;
      rsp_status_ff <= rsp_status_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_mse    = rsp_mse_ff;
   assign rsp_nmse   = rsp_nmse_ff;
   assign rsp_status = rsp_status_ff;

   // the count saturates exactly at 2^COUNT_BITS
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff[COUNT_BITS] |-> (count_ff[COUNT_BITS-1:0] == '0))
      else $error("sample count passed its limit");

   // a division is only launched on an idle divider
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   // a response is never overwritten before it is taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !out_load)
      else $error("pending response overwritten");

   // sums and count are clear once a response is loaded
   a_cleared: assert property (@(posedge clock) disable iff (reset)
      out_load |=> (count_ff == '0 && diff_energy == '0 && orig_energy == '0 && !ovf_ff))
      else $error("state not cleared after a result");

   // overflow status only on a run that saw a dropped pair
   a_status_ovf: assert property (@(posedge clock) disable iff (reset)
      out_load |=> ((rsp_status == STATUS_OVERFLOW) == $past(ovf_ff)))
      else $error("overflow status mismatch");

endmodule

// ===== tb/tb_mse_nmse_accumulator_core.sv =====
`timescale 1ns / 100ps

module tb_mse_nmse_accumulator_core;
   import mna_pkg::*;

   // Run the core at its default sizes.
   localparam int SB = SAMPLE_BITS_DEF;
   localparam int CB = COUNT_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;

   localparam logic [63:0]  COUNT_LIMIT = 64'd1 << CB;
   localparam logic [127:0] OUT_MAX     = (128'd1 << OUT_W) - 128'd1;

   // Two divider passes end every run;
   // leave room well past them before calling the run finished.
   localparam int DRAIN_CYCLES = 300;
   localparam int LONG_HOLD    = 600;
   localparam int TIMEOUT_NS   = 4_000_000;

   typedef struct packed {
      logic [SB-1:0] orig;
      logic [SB-1:0] stego;
      logic          last;
   } sample_pair_type;

   typedef struct packed {
      logic [OUT_W-1:0]    mse;
      logic [OUT_W-1:0]    nmse;
      logic [STATUS_W-1:0] status;
   } metric_type;

   typedef enum int {RUN_MIXED, RUN_SILENT, RUN_MATCHED} run_kind_type;

   logic                clock;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [SB-1:0]       req_orig_sample  = '0;
   logic [SB-1:0]       req_stego_sample = '0;
   logic                req_last         = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [OUT_W-1:0]    rsp_mse;
   logic [OUT_W-1:0]    rsp_nmse;
   logic [STATUS_W-1:0] rsp_status;

   // pairs waiting to be offered, and metrics waiting to come back
   sample_pair_type pairs_to_send[$];
   metric_type      awaited_metrics[$];

   // running sums of the predictor
   logic [63:0] sq_err_sum      = '0;
   logic [63:0] orig_sq_sum     = '0;
   logic [63:0] pair_count      = '0;
   logic        count_full_seen = 1'b0;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_ticket    = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int fail_count     = 0;
   logic req_fired    = 1'b0;

   mse_nmse_accumulator_core #(
      .SAMPLE_BITS(SB),
      .COUNT_BITS (CB),
      .FRAC_BITS  (FB)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_orig_sample (req_orig_sample),
      .req_stego_sample(req_stego_sample),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_mse         (rsp_mse),
      .rsp_nmse        (rsp_nmse),
      .rsp_status      (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the core hangs.
   initial begin
      #(TIMEOUT_NS);
      $display("tb_mse_nmse_accumulator_core: done, errors");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor arithmetic
   // ------------------------------------------------------------------

   // Add two energies, pinning at all ones instead of wrapping.
   function automatic logic [63:0] add_saturating(logic [63:0] a, logic [63:0] b);
      logic [64:0] t;
      t = {1'b0, a} + {1'b0, b};
      return t[64] ? '1 : t[63:0];
   endfunction

   // floor(num * 2^FB / den), pinned at the top of the 48-bit result range.
   function automatic logic [OUT_W-1:0] scaled_ratio(logic [63:0] num, logic [63:0] den);
      logic [127:0] q;
      q = ({64'd0, num} << FB) / {64'd0, den};
      return (q > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : q[OUT_W-1:0];
   endfunction

   // Fold one accepted pair into the sums; on the last pair push the metric
   // the core owes us and clear the sums for the next run.
   task automatic absorb_pair(logic [SB-1:0] o, logic [SB-1:0] s, logic last);
      longint     so;
      longint     ss;
      longint     d;
      metric_type m;
      so = longint'($signed(o));
      ss = longint'($signed(s));
      d  = so - ss;
      // a full counter drops the pair, the last one included
      if (pair_count >= COUNT_LIMIT) begin
         count_full_seen = 1'b1;
      end else begin
         sq_err_sum  = add_saturating(sq_err_sum, 64'(d * d));
         orig_sq_sum = add_saturating(orig_sq_sum, 64'(so * so));
         pair_count  = pair_count + 64'd1;
      end
      if (last) begin
         m.mse = (pair_count != 0) ? scaled_ratio(sq_err_sum, pair_count) : '0;
         if (orig_sq_sum == 0) begin
            // silent original: no ratio, flag it only when there was error
            m.nmse   = '0;
            m.status = (sq_err_sum != 0) ? STATUS_SILENT : STATUS_OK;
         end else begin
            m.nmse   = scaled_ratio(sq_err_sum, orig_sq_sum);
            m.status = STATUS_OK;
         end
         // overflow wins over the silent flag
         if (count_full_seen) m.status = STATUS_OVERFLOW;
         awaited_metrics.push_back(m);
         sq_err_sum      = '0;
         orig_sq_sum     = '0;
         pair_count      = '0;
         count_full_seen = 1'b0;
      end
   endtask

   // ------------------------------------------------------------------
   // Stimulus builders
   // ------------------------------------------------------------------

   function automatic logic [SB-1:0] spread_sample();
      int pick;
      pick = $urandom_range(0, 7);
      case (pick)
         0, 1, 2, 3: return SB'($urandom);
         4: begin
            case ($urandom_range(0, 4))
               0:       return {1'b1, {(SB-1){1'b0}}};
               1:       return {1'b0, {(SB-1){1'b1}}};
               2:       return '1;
               3:       return '0;
               default: return SB'(1);
            endcase
         end
         5:       return SB'($urandom_range(0, 31)) - SB'(16);
         default: return SB'($urandom_range(0, 255)) ^ {SB{$urandom_range(0, 1) == 1}};
      endcase
   endfunction

   task automatic queue_pair(int o, int s, bit last);
      sample_pair_type p;
      p.orig  = SB'(o);
      p.stego = SB'(s);
      p.last  = last;
      pairs_to_send.push_back(p);
   endtask

   // Queue one run of len pairs, flagging the final one as last.
   task automatic queue_run(int len, run_kind_type kind);
      sample_pair_type p;
      for (int i = 0; i < len; i++) begin
         case (kind)
            RUN_SILENT: begin
               p.orig  = '0;
               p.stego = ($urandom_range(0, 2) == 0) ? '0 : spread_sample();
            end
            RUN_MATCHED: begin
               p.orig  = spread_sample();
               p.stego = p.orig;
            end
            default: begin
               p.orig = spread_sample();
               // mostly a lightly altered copy, sometimes unrelated
               if ($urandom_range(0, 2) != 0)
                  p.stego = p.orig + SB'($urandom_range(0, 15)) - SB'(8);
               else
                  p.stego = spread_sample();
            end
         endcase
         p.last = (i == len - 1);
         pairs_to_send.push_back(p);
      end
   endtask

   // Queue whole runs until about n_items pairs are pending. A nonzero
   // max_len keeps runs short; otherwise mostly short with some long ones.
   task automatic queue_random_runs(int n_items, int max_len);
      int           done;
      int           len;
      int           r;
      run_kind_type kind;
      done = 0;
      while (done < n_items) begin
         if (max_len > 0) begin
            len = $urandom_range(1, max_len);
         end else begin
            r = $urandom_range(0, 9);
            if (r < 6)      len = $urandom_range(1, 6);
            else if (r < 9) len = $urandom_range(7, 24);
            else            len = $urandom_range(25, 60);
         end
         r = $urandom_range(0, 7);
         kind = (r == 0) ? RUN_SILENT : (r == 1) ? RUN_MATCHED : RUN_MIXED;
         queue_run(len, kind);
         done += len;
      end
   endtask

   // Hold the sender until everything queued went out and every metric
   // came back.
   task automatic settle_phase();
      while (pairs_to_send.size() != 0 || req_valid) @(posedge clock);
      while (awaited_metrics.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Request driver: change inputs on the falling edge only
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      sample_pair_type nxt;
      if (!reset) begin
         // hold the offered transaction until it has been taken
         if (!req_valid || req_fired) begin
            if (pairs_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pairs_to_send.pop_front();
               req_orig_sample  <= nxt.orig;
               req_stego_sample <= nxt.stego;
               req_last         <= nxt.last;
               req_valid        <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response ready: random stalls, plus one long hold-off on request
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (hold_ticket != hold_served) begin
            hold_served <= hold_ticket;
            hold_left   <= LONG_HOLD;
            rsp_ready   <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: sample both handshakes on the rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      metric_type want;
      req_fired <= !reset && req_valid && req_ready;
      if (!reset) begin
         // check before predicting: a response never belongs to a pair
         // accepted on the same edge
         if (rsp_valid && rsp_ready) begin
            if (awaited_metrics.size() == 0) begin
               $error("unexpected response transaction: mse %0h nmse %0h status %0d",
                      rsp_mse, rsp_nmse, rsp_status);
               fail_count++;
            end else begin
               want = awaited_metrics.pop_front();
               if (rsp_mse !== want.mse) begin
                  $error("mse: expected %0h, actual %0h", want.mse, rsp_mse);
                  fail_count++;
               end
               if (rsp_nmse !== want.nmse) begin
                  $error("nmse: expected %0h, actual %0h", want.nmse, rsp_nmse);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            absorb_pair(req_orig_sample, req_stego_sample, req_last);
      end
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, silence, matched samples, saturation.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_pair(32767, -32768, 1);
      queue_pair(-32768, 32767, 1);
      queue_pair(0, 0, 1);                 // all zero: status ok, both metrics 0
      queue_pair(0, 5, 1);                 // silent original with error
      queue_pair(0, -32768, 1);
      queue_pair(-32768, -32768, 1);       // no error, full-scale original
      queue_pair(1, 1, 1);
      queue_pair(-1, 0, 1);
      // tiny original energy against huge error: nmse pins at the top
      queue_pair(1, -32768, 0);
      queue_pair(0, -32768, 0);
      queue_pair(0, 32767, 0);
      queue_pair(0, -32768, 1);
      // fractional mse: 10 over 3 pairs
      queue_pair(3, 0, 0);
      queue_pair(0, 0, 0);
      queue_pair(0, 1, 1);
      queue_pair(100, 90, 0);
      queue_pair(-50, -40, 1);
      // silent run where the error only shows on one pair
      queue_pair(0, 0, 0);
      queue_pair(0, 7, 0);
      queue_pair(0, 0, 1);
      settle_phase();

      // Random runs under each idling mix.
      queue_random_runs(90, 0);
      settle_phase();

      send_idle_pct = 45;
      queue_random_runs(90, 0);
      settle_phase();

      send_idle_pct  = 0;
      recv_stall_pct = 45;
      queue_random_runs(90, 0);
      settle_phase();

      send_idle_pct  = 22;
      recv_stall_pct = 22;
      queue_random_runs(90, 0);
      settle_phase();

      // Back-pressure: hold off responses for a long stretch while short
      // runs keep coming, so results pile up and the core stalls its input.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_ticket    = hold_ticket + 1;
      queue_random_runs(40, 3);
      settle_phase();

      // let any straggler show up before closing
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && awaited_metrics.size() == 0) begin
         $display("tb_mse_nmse_accumulator_core: done, clean");
      end else begin
         if (awaited_metrics.size() != 0)
            $error("%0d expected response transactions never arrived",
                   awaited_metrics.size());
         $display("tb_mse_nmse_accumulator_core: done, errors");
      end
      $finish;
   end

endmodule
